FILE: design/wsct_pkg.sv
// ----------------------------------------------------------------------------
// wsct_pkg
// Types, codes and helpers shared by the working-set conflict table.
// ----------------------------------------------------------------------------
`default_nettype none

package wsct_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 64;
  localparam int unsigned MAX_RESULTS       = 64;
  localparam int unsigned CONF_W            = 17;
  localparam int unsigned HIT_CNT_W         = $clog2(MAX_RESULTS + 1);
  localparam logic [CONF_W-1:0] ONE_FIX     = 17'd65536;

  // commands
  localparam logic [1:0] CMD_REGISTER = 2'd0;
  localparam logic [1:0] CMD_UPSERT   = 2'd1;
  localparam logic [1:0] CMD_DETECT   = 2'd2;
  localparam logic [1:0] CMD_REMOVE   = 2'd3;

  // access modes
  localparam logic [1:0] MODE_UNK = 2'd0;
  localparam logic [1:0] MODE_RD  = 2'd1;
  localparam logic [1:0] MODE_WR  = 2'd2;
  localparam logic [1:0] MODE_RW  = 2'd3;

  typedef struct packed {
    logic              valid;
    logic              reported;
    logic [63:0]       txn;
    logic [63:0]       key;
    logic [1:0]        mode;
    logic              actual;
    logic [CONF_W-1:0] conf;
  } entry_t;

  function automatic logic [CONF_W-1:0] sat_conf(input logic [CONF_W-1:0] c);
    return (c > ONE_FIX) ? ONE_FIX : c;
  endfunction

  function automatic logic [1:0] combine_mode(input logic [1:0] a, input logic [1:0] b);
    logic [1:0] r;
    if (a == b)             r = a;
    else if (a == MODE_UNK) r = b;
    else if (b == MODE_UNK) r = a;
    else                    r = MODE_RW;
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: design/wsct_req_if.sv
// ----------------------------------------------------------------------------
// wsct_req_if
// Request channel: one command item per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface wsct_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [63:0] txn_id;
  logic [63:0] key;
  logic [1:0]  mode;
  logic        is_actual;
  logic [16:0] confidence;
  logic        first_of_call;

  modport source (output valid, cmd, txn_id, key, mode, is_actual, confidence,
                  first_of_call, input ready);
  modport sink   (input valid, cmd, txn_id, key, mode, is_actual, confidence,
                  first_of_call, output ready);
endinterface

`default_nettype wire

FILE: design/wsct_res_if.sv
// ----------------------------------------------------------------------------
// wsct_res_if
// Result channel: status or one conflict hit per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface wsct_res_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic        hit_valid;
  logic [63:0] peer_txn;
  logic [63:0] hit_key;
  logic        conflict_kind;
  logic [16:0] risk;
  logic        last;

  modport source (output valid, status, hit_valid, peer_txn, hit_key, conflict_kind,
                  risk, last, input ready);
  modport sink   (input valid, status, hit_valid, peer_txn, hit_key, conflict_kind,
                  risk, last, output ready);
endinterface

`default_nettype wire

FILE: design/wsct_ram.sv
// ----------------------------------------------------------------------------
// wsct_ram
// Generic simple dual-port RAM, one write port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module wsct_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: design/working_set_conflict_table.sv
// ----------------------------------------------------------------------------
// working_set_conflict_table
// Table of (transaction, key) working-set entries held in one RAM; register,
// upsert, remove and conflict detection by a full read-modify-write sweep.
// ----------------------------------------------------------------------------
//  channel | dir | content
//  req     | in  | cmd, txn_id, key, mode, is_actual, confidence, first_of_call
//  res     | out | status, hit_valid, peer_txn, hit_key, conflict_kind, risk, last
//
//  Each request sweeps all TABLE_ENTRIES entries, one RAM read per cycle while
//  no held result stalls the sweep; the single RAM read port sets this. req is
//  ready again only after the closing result loads, so a new request is not
//  taken while the previous one is still in its sweep or closing step.
//  After reset a clearing pass zeroes every RAM entry; req stays not-ready
//  meanwhile. A held result pauses the sweep when the next hit needs the
//  output register; the closing result waits for it likewise.
// ----------------------------------------------------------------------------
`default_nettype none

module working_set_conflict_table
  import wsct_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  wsct_req_if.sink  req,
  wsct_res_if.source res
);

  localparam int unsigned IDXW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNTW = IDXW + 1;

  typedef enum logic [3:0] {
    ST_CLR  = 4'b0001,
    ST_IDLE = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  state_t state;

  // latched request
  logic [1:0]        cmd_q;
  logic [63:0]       txn_q, key_q;
  logic [1:0]        mode_q;
  logic              act_q, first_q;
  logic [CONF_W-1:0] conf_q;   // saturated

  // sweep pipeline
  logic [CNTW-1:0] rd_cnt;
  logic            dv;
  logic [IDXW-1:0] ev_idx;
  entry_t          rd_data;

  // insert bookkeeping
  logic            found, free_found;
  logic [IDXW-1:0] match_idx, free_idx;
  entry_t          match_e;

  // pending hit (held back so the final one can carry last)
  logic              pend_v, pend_kind;
  logic [63:0]       pend_txn;
  logic [17:0]       pend_prod;
  logic [HIT_CNT_W-1:0] hit_cnt;

  // output register
  logic              out_v, out_status, out_hit, out_kind, out_last;
  logic [63:0]       out_txn, out_key;
  logic [CONF_W-1:0] out_risk;

  logic can_load;
  assign can_load = !out_v || res.ready;

  // --- evaluation of the entry returned by the RAM -------------------------
  logic is_det, is_rem, is_ins;
  logic own_match, det_match, rep_old, cw, ow, new_hit, stall, issue;
  logic [CONF_W-1:0] pa, pb;
  logic [2*CONF_W-1:0] prod;

  assign is_det = (cmd_q == CMD_DETECT);
  assign is_rem = (cmd_q == CMD_REMOVE);
  assign is_ins = !is_det && !is_rem;

  assign own_match = rd_data.valid && rd_data.txn == txn_q && rd_data.key == key_q;
  assign det_match = rd_data.valid && rd_data.txn != txn_q && rd_data.key == key_q;
  assign rep_old   = first_q ? 1'b0 : rd_data.reported;
  assign cw        = (mode_q != MODE_RD);
  assign ow        = (rd_data.mode != MODE_RD);
  assign new_hit   = dv && is_det && det_match && !rep_old && (cw || ow)
                     && (hit_cnt < HIT_CNT_W'(MAX_RESULTS));
  assign stall     = new_hit && pend_v && !can_load;
  assign issue     = (state == ST_SCAN) && (rd_cnt < CNTW'(TABLE_ENTRIES)) && !stall;

  assign pa   = act_q ? ONE_FIX : conf_q;
  assign pb   = rd_data.actual ? ONE_FIX : sat_conf(rd_data.conf);
  assign prod = pa * pb;

  // output register loads: a earlier hit pushed out mid-sweep, or the closing result
  logic out_load;
  assign out_load = ((state == ST_SCAN) && new_hit && pend_v && !stall)
                    || ((state == ST_FIN) && can_load);

  // --- insert result entry --------------------------------------------------
  entry_t ins_e;
  logic   ins_act;
  always_comb begin
    ins_e = '0;
    if (found) begin
      ins_e      = match_e;
      ins_e.mode = combine_mode(match_e.mode, mode_q);
      ins_act    = match_e.actual || (cmd_q == CMD_UPSERT);
      ins_e.actual = ins_act;
      if (ins_act)                   ins_e.conf = ONE_FIX;
      else if (conf_q > match_e.conf) ins_e.conf = conf_q;
    end else begin
      ins_act        = act_q || (cmd_q == CMD_UPSERT);
      ins_e.valid    = 1'b1;
      ins_e.reported = 1'b0;
      ins_e.txn      = txn_q;
      ins_e.key      = key_q;
      ins_e.mode     = mode_q;
      ins_e.actual   = ins_act;
      ins_e.conf     = ins_act ? ONE_FIX : conf_q;
    end
  end

  // --- RAM write port -------------------------------------------------------
  logic            we;
  logic [IDXW-1:0] waddr;
  entry_t          wdata;
  always_comb begin
    we    = 1'b0;
    waddr = ev_idx;
    wdata = rd_data;
    unique case (state)
      ST_CLR: begin
        we    = 1'b1;
        waddr = rd_cnt[IDXW-1:0];
        wdata = '0;
      end
      ST_SCAN: begin
        if (dv && !stall) begin
          if (is_det) begin
            we             = 1'b1;
            wdata.reported = det_match ? 1'b1 : rep_old;
          end else if (is_rem && rd_data.valid && rd_data.txn == txn_q) begin
            we             = 1'b1;
            wdata.valid    = 1'b0;
            wdata.reported = 1'b0;
          end
        end
      end
      ST_FIN: begin
        if (is_ins && can_load && (found || free_found)) begin
          we    = 1'b1;
          waddr = found ? match_idx : free_idx;
          wdata = ins_e;
        end
      end
      default: ;
    endcase
  end

  logic [$bits(entry_t)-1:0] rd_raw;
  assign rd_data = entry_t'(rd_raw);

  wsct_ram #(.WIDTH($bits(entry_t)), .DEPTH(TABLE_ENTRIES)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (issue),
    .raddr (rd_cnt[IDXW-1:0]),
    .rdata (rd_raw)
  );

  assign req.ready = (state == ST_IDLE);

  // clamp of a registered product
  function automatic logic [CONF_W-1:0] clamp_risk(input logic [17:0] p);
    return (p > 18'(ONE_FIX)) ? ONE_FIX : p[CONF_W-1:0];
  endfunction

  // --- control and datapath registers ---------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLR;
      rd_cnt  <= '0;
      dv      <= 1'b0;
      pend_v  <= 1'b0;
      out_v   <= 1'b0;
      hit_cnt <= '0;
      found   <= 1'b0;
      free_found <= 1'b0;
    end else begin
      if (out_load)       out_v <= 1'b1;
      else if (res.ready) out_v <= 1'b0;

      unique case (state)
        ST_CLR: begin
          rd_cnt <= rd_cnt + 1'b1;
          if (rd_cnt == CNTW'(TABLE_ENTRIES - 1)) begin
            state <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (req.valid) begin
            cmd_q      <= req.cmd;
            txn_q      <= req.txn_id;
            key_q      <= req.key;
            mode_q     <= req.mode;
            act_q      <= req.is_actual;
            first_q    <= req.first_of_call;
            conf_q     <= sat_conf(req.confidence);
            rd_cnt     <= '0;
            dv         <= 1'b0;
            hit_cnt    <= '0;
            pend_v     <= 1'b0;
            found      <= 1'b0;
            free_found <= 1'b0;
            state      <= ST_SCAN;
          end
        end

        ST_SCAN: begin
          if (issue) rd_cnt <= rd_cnt + 1'b1;
          if (!stall) begin
            dv     <= issue;
            ev_idx <= rd_cnt[IDXW-1:0];
          end
          if (dv && !stall) begin
            // lookup for register / upsert
            if (own_match && !found) begin
              found     <= 1'b1;
              match_idx <= ev_idx;
              match_e   <= rd_data;
            end
            if (!rd_data.valid && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= ev_idx;
            end
            if (new_hit) begin
              if (pend_v) begin
                out_status <= 1'b0;
                out_hit    <= 1'b1;
                out_txn    <= pend_txn;
                out_key    <= key_q;
                out_kind   <= pend_kind;
                out_risk   <= clamp_risk(pend_prod);
                out_last   <= 1'b0;
              end
              pend_v    <= 1'b1;
              pend_txn  <= rd_data.txn;
              pend_kind <= cw && ow;
              pend_prod <= prod[2*CONF_W-1:16];
              hit_cnt   <= hit_cnt + 1'b1;
            end
          end
          if (rd_cnt == CNTW'(TABLE_ENTRIES) && !dv) state <= ST_FIN;
        end

        ST_FIN: begin
          if (can_load) begin
            out_last <= 1'b1;
            if (pend_v) begin
              out_status <= 1'b0;
              out_hit    <= 1'b1;
              out_txn    <= pend_txn;
              out_key    <= key_q;
              out_kind   <= pend_kind;
              out_risk   <= clamp_risk(pend_prod);
            end else begin
              out_status <= is_ins && !found && !free_found;
              out_hit    <= 1'b0;
              out_txn    <= '0;
              out_key    <= '0;
              out_kind   <= 1'b0;
              out_risk   <= '0;
            end
            pend_v <= 1'b0;
            state  <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  assign res.valid         = out_v;
  assign res.status        = out_status;
  assign res.hit_valid     = out_hit;
  assign res.peer_txn      = out_txn;
  assign res.hit_key       = out_key;
  assign res.conflict_kind = out_kind;
  assign res.risk          = out_risk;
  assign res.last          = out_last;

endmodule

`default_nettype wire
